// File: design/water_refraction_shader_unit_assert.svh
// assertion macros used by the shader unit
`ifndef WATER_REFRACTION_SHADER_UNIT_ASSERT_SVH
`define WATER_REFRACTION_SHADER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define WRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define WRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wrs_pkg.sv
package wrs_pkg;

  // texture and shading geometry
  localparam int TEX_SHIFT     = 7;
  localparam int SHADE_SHIFT   = 8;
  localparam int REFRACT_SHIFT = 8;
  localparam int COORD_BITS    = 10;

  // field widths
  localparam int STORE_BITS  = 14;
  localparam int STORE_DEPTH = 1 << STORE_BITS;
  localparam int TEX_W       = 16;
  localparam int COORD_W     = 10;
  localparam int HEIGHT_W    = 32;
  localparam int DIFF_W      = HEIGHT_W + 1;
  localparam int FULL_W      = 2 * TEX_SHIFT + STORE_BITS;

  // shade is saturated to +-16: beyond that every channel clamps the same way
  localparam int SHADE_W   = 6;
  localparam int SHADE_MAX = 16;

  typedef enum logic {
    OP_SHADE = 1'b0,
    OP_LOAD  = 1'b1
  } op_e;

  typedef logic signed [SHADE_W-1:0] shade_t;
  typedef logic [STORE_BITS-1:0]     addr_t;
  typedef logic [TEX_W-1:0]          texel_t;

  typedef struct packed {
    logic   wr_en;
    logic   rd_en;
    addr_t  addr;
    texel_t wdata;
  } ram_req_t;

endpackage

// File: design/wrs_tex_ram.sv
module wrs_tex_ram (
  input  logic              clk_i,
  input  wrs_pkg::ram_req_t req_i,
  output wrs_pkg::texel_t   rdata_o
);

  wrs_pkg::texel_t mem_q [wrs_pkg::STORE_DEPTH];
  wrs_pkg::texel_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/wrs_addr.sv
module wrs_addr (
  input  logic [wrs_pkg::COORD_W-1:0]         pixel_x_i,
  input  logic [wrs_pkg::COORD_W-1:0]         pixel_y_i,
  input  logic signed [wrs_pkg::HEIGHT_W-1:0] height_center_i,
  input  logic signed [wrs_pkg::HEIGHT_W-1:0] height_below_i,
  input  logic signed [wrs_pkg::HEIGHT_W-1:0] height_right_i,
  output wrs_pkg::addr_t                      addr_o,
  output wrs_pkg::shade_t                     shade_o
);

  localparam logic [wrs_pkg::COORD_W-1:0] PixMask =
    wrs_pkg::COORD_W'((1 << wrs_pkg::COORD_BITS) - 1);

  logic signed [wrs_pkg::DIFF_W-1:0] dy;
  logic signed [wrs_pkg::DIFF_W-1:0] dx;
  logic signed [wrs_pkg::DIFF_W-1:0] dy_shade;
  logic signed [wrs_pkg::DIFF_W-1:0] dy_refr;
  logic signed [wrs_pkg::DIFF_W-1:0] dx_refr;
  logic [wrs_pkg::DIFF_W-1:0]        sum_x;
  logic [wrs_pkg::DIFF_W-1:0]        sum_y;
  logic [wrs_pkg::TEX_SHIFT-1:0]     tex_x;
  logic [wrs_pkg::TEX_SHIFT-1:0]     tex_y;
  logic [wrs_pkg::FULL_W-1:0]        full_addr;

  // exact height differences
  assign dy = {height_center_i[wrs_pkg::HEIGHT_W-1], height_center_i}
            - {height_below_i[wrs_pkg::HEIGHT_W-1], height_below_i};
  assign dx = {height_center_i[wrs_pkg::HEIGHT_W-1], height_center_i}
            - {height_right_i[wrs_pkg::HEIGHT_W-1], height_right_i};

  assign dy_shade = dy >>> wrs_pkg::SHADE_SHIFT;
  assign dy_refr  = dy >>> wrs_pkg::REFRACT_SHIFT;
  assign dx_refr  = dx >>> wrs_pkg::REFRACT_SHIFT;

  // shade: six maps to four, then saturate
  always_comb begin
    if (dy_shade > wrs_pkg::SHADE_MAX) begin
      shade_o = wrs_pkg::SHADE_W'(wrs_pkg::SHADE_MAX);
    end else if (dy_shade < -wrs_pkg::SHADE_MAX) begin
      shade_o = wrs_pkg::SHADE_W'(-wrs_pkg::SHADE_MAX);
    end else if (dy_shade == 6) begin
      shade_o = 6'sd4;
    end else begin
      shade_o = dy_shade[wrs_pkg::SHADE_W-1:0];
    end
  end

  // displaced fetch coordinates, wrapped to the texture size
  assign sum_x = unsigned'(dx_refr) + wrs_pkg::DIFF_W'(pixel_x_i & PixMask);
  assign sum_y = unsigned'(dy_refr) + wrs_pkg::DIFF_W'(pixel_y_i & PixMask);
  assign tex_x = sum_x[wrs_pkg::TEX_SHIFT-1:0];
  assign tex_y = sum_y[wrs_pkg::TEX_SHIFT-1:0];

  // store address wraps to its own size
  assign full_addr = wrs_pkg::FULL_W'({tex_y, tex_x});
  assign addr_o    = full_addr[wrs_pkg::STORE_BITS-1:0];

endmodule

// File: design/wrs_shade.sv
module wrs_shade (
  input  wrs_pkg::shade_t shade_i,
  input  wrs_pkg::texel_t texel_i,
  output wrs_pkg::texel_t color_o
);

  logic signed [13:0] red;
  logic signed [9:0]  green;
  logic signed [6:0]  blue;
  logic [11:0]        red_c;
  logic [7:0]         green_c;
  logic [3:0]         blue_c;

  // darken each channel by the shade at its own weight
  assign red   = $signed({2'b00, texel_i[11:8], 8'h00}) - $signed({shade_i, 8'h00});
  assign green = $signed({2'b00, texel_i[7:4], 4'h0}) - $signed({shade_i, 4'h0});
  assign blue  = $signed({3'b000, texel_i[3:0]}) - $signed({shade_i[5], shade_i});

  // red clamps to its range
  always_comb begin
    if (red > 14'sh0FFF) begin
      red_c = 12'hFFF;
    end else if (red < 14'sh0100) begin
      red_c = 12'h100;
    end else begin
      red_c = red[11:0];
    end
  end

  // green saturates to all ones above 0xfe and is raised to 0x10 below 0x10
  always_comb begin
    if (green > 10'sh0FE) begin
      green_c = 8'hFF;
    end else if (green < 10'sh010) begin
      green_c = 8'h10;
    end else begin
      green_c = green[7:0];
    end
  end

  // negative blue is dropped to zero, blue above 0xe saturates to all ones
  always_comb begin
    if (blue < 7'sh00) begin
      blue_c = 4'h0;
    end else if (blue > 7'sh0E) begin
      blue_c = 4'hF;
    end else begin
      blue_c = blue[3:0];
    end
  end

  assign color_o = {4'h0, red_c} | {8'h00, green_c} | {12'h000, blue_c};

endmodule

// File: design/water_refraction_shader_unit.sv
// Water refraction shader.
// Input channel (valid_i / stall_o) carries one transaction per cycle while stall_o is low: either
// a texture load (operation_i = 1) that writes texel_value_i at texel_index_i,
// or a shade request (operation_i = 0) with pixel position and three height
// samples. Each shade request gives one transaction on the output channel
// (valid_o / stall_i, pixel_color_o); a load gives none.
// Throughput: one transaction per clock while stall_o is low, loads and shades
// mixed freely. A shade passes the input register, the texture read register
// and the result register, in that order, before it shows on pixel_color_o.
// The texture port is the only memory access, one read or write per item.
// Stages advance in order, so a shade sees every load accepted before it.
// If stall_i stays high the result register holds and the pipeline fills;
// stall_o rises once all three stages are occupied.
// Reset clears all stage valids; texture contents are undefined after reset
// and each texel must be loaded before a shade fetches it.
module water_refraction_shader_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic                                operation_i,
  input  logic [wrs_pkg::STORE_BITS-1:0]      texel_index_i,
  input  logic [wrs_pkg::TEX_W-1:0]           texel_value_i,
  input  logic [wrs_pkg::COORD_W-1:0]         pixel_x_i,
  input  logic [wrs_pkg::COORD_W-1:0]         pixel_y_i,
  input  logic signed [wrs_pkg::HEIGHT_W-1:0] height_center_i,
  input  logic signed [wrs_pkg::HEIGHT_W-1:0] height_below_i,
  input  logic signed [wrs_pkg::HEIGHT_W-1:0] height_right_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic [wrs_pkg::TEX_W-1:0]           pixel_color_o
);

  `include "water_refraction_shader_unit_assert.svh"

  logic                                s1_valid_q;
  wrs_pkg::op_e                        s1_op_q;
  wrs_pkg::addr_t                      s1_index_q;
  wrs_pkg::texel_t                     s1_value_q;
  logic [wrs_pkg::COORD_W-1:0]         s1_x_q;
  logic [wrs_pkg::COORD_W-1:0]         s1_y_q;
  logic signed [wrs_pkg::HEIGHT_W-1:0] s1_hc_q;
  logic signed [wrs_pkg::HEIGHT_W-1:0] s1_hb_q;
  logic signed [wrs_pkg::HEIGHT_W-1:0] s1_hr_q;

  logic                                s2_valid_q;
  wrs_pkg::shade_t                     s2_shade_q;

  logic                                out_valid_q;
  wrs_pkg::texel_t                     pixel_color_q;

  logic              in_accept;
  logic              out_free;
  logic              s2_free;
  logic              s1_move;
  wrs_pkg::addr_t    fetch_addr;
  wrs_pkg::shade_t   s1_shade;
  wrs_pkg::ram_req_t ram_req;
  wrs_pkg::texel_t   texel;
  wrs_pkg::texel_t   color;

  // stage flow control
  assign out_free  = !out_valid_q || !stall_i;
  assign s2_free   = !s2_valid_q || out_free;
  assign s1_move   = s1_valid_q && s2_free;
  assign stall_o   = s1_valid_q && !s2_free;
  assign in_accept = valid_i && !stall_o;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!s1_valid_q || s2_free) begin
        s1_valid_q <= in_accept;
      end
      if (s2_free) begin
        s2_valid_q <= s1_move && (s1_op_q == wrs_pkg::OP_SHADE);
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= wrs_pkg::op_e'(operation_i);
      s1_index_q <= texel_index_i;
      s1_value_q <= texel_value_i;
      s1_x_q     <= pixel_x_i;
      s1_y_q     <= pixel_y_i;
      s1_hc_q    <= height_center_i;
      s1_hb_q    <= height_below_i;
      s1_hr_q    <= height_right_i;
    end
  end

  // fetch address and shade
  wrs_addr u_addr (
    .pixel_x_i       (s1_x_q),
    .pixel_y_i       (s1_y_q),
    .height_center_i (s1_hc_q),
    .height_below_i  (s1_hb_q),
    .height_right_i  (s1_hr_q),
    .addr_o          (fetch_addr),
    .shade_o         (s1_shade)
  );

  // texture port: loads write, shades read
  always_comb begin
    ram_req.wr_en = s1_move && (s1_op_q == wrs_pkg::OP_LOAD);
    ram_req.rd_en = s1_move && (s1_op_q == wrs_pkg::OP_SHADE);
    ram_req.addr  = (s1_op_q == wrs_pkg::OP_LOAD) ? s1_index_q : fetch_addr;
    ram_req.wdata = s1_value_q;
  end

  wrs_tex_ram u_tex_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (texel)
  );

  // shade travels alongside the texel read
  always_ff @(posedge clk_i) begin
    if (ram_req.rd_en) begin
      s2_shade_q <= s1_shade;
    end
  end

  wrs_shade u_shade (
    .shade_i (s2_shade_q),
    .texel_i (texel),
    .color_o (color)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (out_free && s2_valid_q) begin
      pixel_color_q <= color;
    end
  end

  assign valid_o       = out_valid_q;
  assign pixel_color_o = pixel_color_q;

  // checks
  `WRS_ASSERT_IMP(a_stall_only_full, stall_o,
    s1_valid_q && s2_valid_q && out_valid_q && stall_i,
    "input stalled while the pipeline had room")
  `WRS_ASSERT_NXT(a_load_no_result, s1_move && (s1_op_q == wrs_pkg::OP_LOAD),
    !s2_valid_q, "load transaction reached the shading stage")
  `WRS_ASSERT_NXT(a_s2_advances, s2_valid_q && out_free, out_valid_q,
    "shaded pixel lost between read and result stage")
  `WRS_ASSERT_IMP(a_shade_range, s2_valid_q,
    s2_shade_q != 6'sd6 && s2_shade_q <= 6'sd16 && s2_shade_q >= -6'sd16,
    "shade outside its saturated range")

endmodule
